// ===== src/sfsp_pkg.sv =====
// shared types, constants and helpers for the servo frame stream parser
package sfsp_pkg;

	localparam logic [7:0] HDR_BYTE        = 8'h55;
	localparam logic [7:0] LEN_MIN         = 8'd2;
	localparam logic [8:0] LEN_ADD         = 9'd2;
	localparam logic [8:0] CMD_POS         = 9'd3;
	localparam logic [8:0] COUNT_POS       = 9'd4;
	localparam logic [8:0] TIME_LO_POS     = 9'd5;
	localparam logic [8:0] TIME_HI_POS     = 9'd6;
	localparam logic [8:0] MOVE_BASE       = 9'd7;
	localparam logic [8:0] READ_BASE       = 9'd5;
	localparam logic [8:0] MOVE_MIN_SIZE   = 9'd7;
	localparam logic [8:0] READ_MIN_SIZE   = 9'd5;
	localparam logic [7:0] MOVE_OPCODE_RST = 8'd3;
	localparam logic [7:0] READ_OPCODE_RST = 8'd21;
	localparam int         FIFO_DEPTH      = 4;
	localparam int         CFG_IDX_W       = 1;

	typedef enum logic [2:0] {
		PH_HUNT0,
		PH_HUNT1,
		PH_LEN,
		PH_BODY,
		PH_SKIP
	} phase_t;

	typedef enum logic [1:0] {
		FK_MOVE,
		FK_REQ,
		FK_RESP,
		FK_UNKNOWN
	} frame_kind_t;

	typedef enum logic [1:0] {
		RK_ENTRY,
		RK_ID,
		RK_SUMMARY
	} record_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MOVE_OPCODE,
		CFG_READ_OPCODE
	} cfg_index_t;

	typedef enum logic [1:0] {
		SLOT_ID,
		SLOT_POS_LO,
		SLOT_POS_HI
	} slot_t;

	typedef struct packed {
		logic [1:0]  record_kind;
		logic [1:0]  frame_kind;
		logic [7:0]  command_code;
		logic [15:0] move_time_ms;
		logic [7:0]  declared_count;
		logic [7:0]  entry_index;
		logic [7:0]  servo_id;
		logic [15:0] servo_position;
		logic [8:0]  frame_bytes;
		logic        last;
	} result_t;

	typedef struct packed {
		logic entry_v;
		logic summary_v;
	} push_t;

	// divide by three through a reciprocal, exact for any 9-bit value
	function automatic logic [7:0] div3(input logic [8:0] x);
		logic [19:0] p;
		p = {11'd0, x} * 20'd683;
		return p[18:11];
	endfunction

	function automatic logic [7:0] min8(input logic [7:0] a, input logic [7:0] b);
		return (a < b) ? a : b;
	endfunction

endpackage

// ===== src/servo_frame_stream_parser.sv =====
// top level: input register, opcode registers, frame parser and result queue
// an accepted byte is held in the input register, and the parser then writes its results into the result queue
// throughput: one byte per cycle while the result queue has room; a closing byte with an entry makes two beats
// the result queue (depth FIFO_DEPTH) must hold room for two beats to take a byte
// reset: parser hunts for header, queue empty, opcodes 3 (move) and 21 (read)
module servo_frame_stream_parser #(
	parameter int FIFO_DEPTH = sfsp_pkg::FIFO_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rx_valid,
	output logic                           rx_ready,
	input  logic [7:0]                     rx_byte,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sfsp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     record_kind,
	output logic [1:0]                     frame_kind,
	output logic [7:0]                     command_code,
	output logic [15:0]                    move_time_ms,
	output logic [7:0]                     declared_count,
	output logic [7:0]                     entry_index,
	output logic [7:0]                     servo_id,
	output logic [15:0]                    servo_position,
	output logic [8:0]                     frame_bytes,
	output logic                           last
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic [7:0]        move_opcode_q;
	logic [7:0]        read_opcode_q;
	logic              step;
	logic              space2;
	logic              pop;
	sfsp_pkg::push_t   push;
	sfsp_pkg::result_t res_entry, res_summary, head;

	assign step      = valid_s1 && space2;
	assign rx_ready  = !valid_s1 || step;
	assign cfg_ready = 1'b1;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready)
			byte_s1 <= rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_opcode_q <= sfsp_pkg::MOVE_OPCODE_RST;
			read_opcode_q <= sfsp_pkg::READ_OPCODE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				sfsp_pkg::CFG_MOVE_OPCODE: move_opcode_q <= cfg_data;
				sfsp_pkg::CFG_READ_OPCODE: read_opcode_q <= cfg_data;
				default: ;
			endcase
		end
	end

	sfsp_parser u_parser (
		.clk                  (clk),
		.arst_n               (arst_n),
		.step                 (step),
		.rx_byte              (byte_s1),
		.move_opcode          (move_opcode_q),
		.read_position_opcode (read_opcode_q),
		.push                 (push),
		.res_entry            (res_entry),
		.res_summary          (res_summary)
	);

	sfsp_result_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_entry   (res_entry),
		.wr_summary (res_summary),
		.pop        (pop),
		.rd_data    (head),
		.not_empty  (out_valid),
		.space2     (space2)
	);

	assign record_kind    = head.record_kind;
	assign frame_kind     = head.frame_kind;
	assign command_code   = head.command_code;
	assign move_time_ms   = head.move_time_ms;
	assign declared_count = head.declared_count;
	assign entry_index    = head.entry_index;
	assign servo_id       = head.servo_id;
	assign servo_position = head.servo_position;
	assign frame_bytes    = head.frame_bytes;
	assign last           = head.last;

endmodule

// ===== src/sfsp_parser.sv =====
// frame parsing state machine producing entry and summary results per byte
module sfsp_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        rx_byte,
	input  logic [7:0]        move_opcode,
	input  logic [7:0]        read_position_opcode,
	output sfsp_pkg::push_t   push,
	output sfsp_pkg::result_t res_entry,
	output sfsp_pkg::result_t res_summary
);

	sfsp_pkg::phase_t      phase_q, phase_d;
	logic [8:0]            cnt_q, cnt_d;
	logic [8:0]            fsize_q, fsize_d;
	logic [7:0]            cmd_q, cmd_d;
	logic [7:0]            count_q, count_d;
	logic [15:0]           time_q, time_d;
	logic [7:0]            limit_q, limit_d;
	logic [7:0]            done_q, done_d;
	logic [15:0]           partial_q, partial_d;
	sfsp_pkg::frame_kind_t kind_q, kind_d;
	sfsp_pkg::slot_t       slot_q, slot_d;

	logic [9:0]  cnt_inc;
	logic        at_end;
	logic        is_move;
	logic        short_frame;
	logic [8:0]  base;
	logic [8:0]  payload;
	logic [8:0]  move_room;
	logic [7:0]  entry_id;
	logic [15:0] entry_pos;
	sfsp_pkg::record_kind_t entry_kind;

	always_comb begin
		phase_d     = phase_q;
		cnt_d       = cnt_q;
		fsize_d     = fsize_q;
		cmd_d       = cmd_q;
		count_d     = count_q;
		time_d      = time_q;
		limit_d     = limit_q;
		done_d      = done_q;
		partial_d   = partial_q;
		kind_d      = kind_q;
		slot_d      = slot_q;
		push        = '0;
		entry_id    = 8'd0;
		entry_pos   = 16'd0;
		entry_kind  = sfsp_pkg::RK_ENTRY;
		short_frame = 1'b0;
		cnt_inc     = {1'b0, cnt_q} + 10'd1;
		at_end      = cnt_inc >= {1'b0, fsize_q};
		is_move     = kind_q == sfsp_pkg::FK_MOVE;
		base        = is_move ? sfsp_pkg::MOVE_BASE : sfsp_pkg::READ_BASE;
		payload     = fsize_q - sfsp_pkg::READ_BASE;
		move_room   = fsize_q - sfsp_pkg::MOVE_MIN_SIZE;
		if (step) begin
			case (phase_q)
				sfsp_pkg::PH_HUNT0: begin
					if (rx_byte == sfsp_pkg::HDR_BYTE)
						phase_d = sfsp_pkg::PH_HUNT1;
				end
				sfsp_pkg::PH_HUNT1: begin
					phase_d = (rx_byte == sfsp_pkg::HDR_BYTE) ? sfsp_pkg::PH_LEN
						: sfsp_pkg::PH_HUNT0;
				end
				sfsp_pkg::PH_LEN: begin
					if (rx_byte < sfsp_pkg::LEN_MIN) begin
						phase_d = sfsp_pkg::PH_HUNT0;
					end else begin
						fsize_d = {1'b0, rx_byte} + sfsp_pkg::LEN_ADD;
						cnt_d   = sfsp_pkg::CMD_POS;
						phase_d = sfsp_pkg::PH_BODY;
					end
				end
				sfsp_pkg::PH_SKIP: begin
					if (at_end)
						phase_d = sfsp_pkg::PH_HUNT0;
					cnt_d = cnt_inc[8:0];
				end
				sfsp_pkg::PH_BODY: begin
					if (cnt_q == sfsp_pkg::CMD_POS) begin
						cmd_d     = rx_byte;
						count_d   = 8'd0;
						time_d    = 16'd0;
						limit_d   = 8'd0;
						done_d    = 8'd0;
						partial_d = 16'd0;
						slot_d    = sfsp_pkg::SLOT_ID;
						if (rx_byte == move_opcode) begin
							kind_d      = sfsp_pkg::FK_MOVE;
							short_frame = fsize_q < sfsp_pkg::MOVE_MIN_SIZE;
						end else if (rx_byte == read_position_opcode) begin
							kind_d      = sfsp_pkg::FK_REQ;
							short_frame = fsize_q < sfsp_pkg::READ_MIN_SIZE;
						end else begin
							kind_d = sfsp_pkg::FK_UNKNOWN;
						end
					end else if (kind_q != sfsp_pkg::FK_UNKNOWN) begin
						if (cnt_q == sfsp_pkg::COUNT_POS) begin
							count_d = rx_byte;
							if (is_move) begin
								limit_d = sfsp_pkg::min8(rx_byte, sfsp_pkg::div3(move_room));
							end else if (payload == {1'b0, rx_byte}) begin
								kind_d  = sfsp_pkg::FK_REQ;
								limit_d = rx_byte;
							end else begin
								kind_d  = sfsp_pkg::FK_RESP;
								limit_d = sfsp_pkg::min8(rx_byte, sfsp_pkg::div3(payload));
							end
						end else if (is_move && cnt_q == sfsp_pkg::TIME_LO_POS) begin
							time_d[7:0] = rx_byte;
						end else if (is_move && cnt_q == sfsp_pkg::TIME_HI_POS) begin
							time_d[15:8] = rx_byte;
						end else if (cnt_q >= base && done_q < limit_q) begin
							if (kind_q == sfsp_pkg::FK_REQ) begin
								push.entry_v = 1'b1;
								entry_kind   = sfsp_pkg::RK_ID;
								entry_id     = rx_byte;
								done_d       = done_q + 8'd1;
							end else begin
								case (slot_q)
									sfsp_pkg::SLOT_ID: begin
										partial_d = {8'd0, rx_byte};
										slot_d    = sfsp_pkg::SLOT_POS_LO;
									end
									sfsp_pkg::SLOT_POS_LO: begin
										partial_d = {rx_byte, partial_q[7:0]};
										slot_d    = sfsp_pkg::SLOT_POS_HI;
									end
									default: begin
										push.entry_v = 1'b1;
										entry_id     = partial_q[7:0];
										entry_pos    = {rx_byte, partial_q[15:8]};
										done_d       = done_q + 8'd1;
										slot_d       = sfsp_pkg::SLOT_ID;
									end
								endcase
							end
						end
					end
					cnt_d = cnt_inc[8:0];
					if (short_frame) begin
						phase_d = at_end ? sfsp_pkg::PH_HUNT0 : sfsp_pkg::PH_SKIP;
					end else if (at_end) begin
						push.summary_v = 1'b1;
						phase_d        = sfsp_pkg::PH_HUNT0;
					end
				end
				default: begin
					phase_d = sfsp_pkg::PH_HUNT0;
				end
			endcase
		end
	end

	always_comb begin
		res_entry.record_kind    = entry_kind;
		res_entry.frame_kind     = kind_d;
		res_entry.command_code   = cmd_d;
		res_entry.move_time_ms   = (kind_d == sfsp_pkg::FK_MOVE) ? time_d : 16'd0;
		res_entry.declared_count = (kind_d == sfsp_pkg::FK_UNKNOWN) ? 8'd0 : count_d;
		res_entry.entry_index    = done_q;
		res_entry.servo_id       = entry_id;
		res_entry.servo_position = entry_pos;
		res_entry.frame_bytes    = fsize_d;
		res_entry.last           = 1'b0;

		res_summary                = res_entry;
		res_summary.record_kind    = sfsp_pkg::RK_SUMMARY;
		res_summary.entry_index    = done_d;
		res_summary.servo_id       = 8'd0;
		res_summary.servo_position = 16'd0;
		res_summary.last           = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= sfsp_pkg::PH_HUNT0;
			cnt_q     <= 9'd0;
			fsize_q   <= 9'd0;
			cmd_q     <= 8'd0;
			count_q   <= 8'd0;
			time_q    <= 16'd0;
			limit_q   <= 8'd0;
			done_q    <= 8'd0;
			partial_q <= 16'd0;
			kind_q    <= sfsp_pkg::FK_MOVE;
			slot_q    <= sfsp_pkg::SLOT_ID;
		end else begin
			phase_q   <= phase_d;
			cnt_q     <= cnt_d;
			fsize_q   <= fsize_d;
			cmd_q     <= cmd_d;
			count_q   <= count_d;
			time_q    <= time_d;
			limit_q   <= limit_d;
			done_q    <= done_d;
			partial_q <= partial_d;
			kind_q    <= kind_d;
			slot_q    <= slot_d;
		end
	end

	a_summary_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		push.summary_v |=> phase_q == sfsp_pkg::PH_HUNT0)
		else $error("summary beat did not return parser to header hunt");

	a_entry_in_body: assert property (@(posedge clk) disable iff (!arst_n)
		push.entry_v |-> (phase_q == sfsp_pkg::PH_BODY && done_q < limit_q))
		else $error("entry produced outside frame body or beyond limit");

	a_entry_kind: assert property (@(posedge clk) disable iff (!arst_n)
		push.entry_v |-> (kind_q == sfsp_pkg::FK_MOVE || kind_q == sfsp_pkg::FK_REQ
			|| kind_q == sfsp_pkg::FK_RESP))
		else $error("entry produced for unknown command frame");

endmodule

// ===== src/sfsp_result_fifo.sv =====
// small result queue taking up to two beats per cycle and giving one
module sfsp_result_fifo #(
	parameter int DEPTH = sfsp_pkg::FIFO_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sfsp_pkg::push_t   push,
	input  sfsp_pkg::result_t wr_entry,
	input  sfsp_pkg::result_t wr_summary,
	input  logic              pop,
	output sfsp_pkg::result_t rd_data,
	output logic              not_empty,
	output logic              space2
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	sfsp_pkg::result_t mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q, wr_nxt;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [1:0]        n_push;
	sfsp_pkg::result_t w0;

	function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign n_push    = {1'b0, push.entry_v} + {1'b0, push.summary_v};
	assign w0        = push.entry_v ? wr_entry : wr_summary;
	assign wr_nxt    = nxt(wr_q);
	assign count_d   = count_q + CNT_W'(n_push) - CNT_W'(pop);
	assign not_empty = count_q != '0;
	assign space2    = count_q <= CNT_W'(DEPTH - 2);
	assign rd_data   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (n_push != 2'd0)
			mem_q[wr_q] <= w0;
		if (n_push == 2'd2)
			mem_q[wr_nxt] <= wr_summary;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			count_q <= count_d;
			if (pop)
				rd_q <= nxt(rd_q);
			if (n_push == 2'd2)
				wr_q <= nxt(wr_nxt);
			else if (n_push == 2'd1)
				wr_q <= wr_nxt;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, count_q} + (CNT_W + 1)'(n_push) <= (CNT_W + 1)'(DEPTH))
		else $error("result queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("result queue read while empty");

	a_head_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(not_empty && !pop) |=> $stable(rd_data))
		else $error("queue head changed while waiting");

endmodule
